// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes for the software timer table
// Request and result codes, field widths.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned IntW  = 31;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HdlW  = 4;

  localparam logic [IntW-1:0] CapReset = 31'd3600000;

  localparam logic [2:0] ReqAdd   = 3'd0;
  localparam logic [2:0] ReqResch = 3'd1;
  localparam logic [2:0] ReqUnsch = 3'd2;
  localparam logic [2:0] ReqRem   = 3'd3;
  localparam logic [2:0] ReqExec  = 3'd4;
  localparam logic [2:0] ReqNext  = 3'd5;

  localparam logic [2:0] KindDone  = 3'd0;
  localparam logic [2:0] KindFull  = 3'd1;
  localparam logic [2:0] KindNoSuch = 3'd2;
  localparam logic [2:0] KindFired = 3'd3;
  localparam logic [2:0] KindWait  = 3'd4;
  localparam logic [2:0] KindScan  = 3'd5;

  typedef struct packed {
    logic [2:0]      kind;
    logic [HdlW-1:0] handle;
    logic [IntW-1:0] wait_ms;
    logic            last;
  } result_t;

endpackage

// ===== rtl/stt_mem.sv =====
// ----------------------------------------------------------------------------
// stt_mem: timer entry store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stt_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 63
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/software_timer_table.sv =====
// ----------------------------------------------------------------------------
// software_timer_table: table of one-shot and periodic millisecond timers
// Sequencer over a one-port-read entry memory plus per-slot flag registers.
// ----------------------------------------------------------------------------
// Add/reschedule/unschedule/remove pass through StRead and StOut to the output register;
// the next request is taken once back in idle. Execute and next walk the entry memory
// one slot a cycle while no fired word waits on a stalled output, then StFlush and StOut.
// Execute emits each fired word as it is found; a stalled output holds the walk.
// Reset clears in-use and unscheduled flags and loads the wait cap; entry
// memory contents are not cleared.
module software_timer_table #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [stt_pkg::IntW-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            req_type_i,
  input  logic [3:0]            slot_i,
  input  logic [stt_pkg::IntW-1:0] first_interval_i,
  input  logic [stt_pkg::IntW-1:0] second_interval_i,
  input  logic [stt_pkg::TimeW-1:0] now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            result_kind_o,
  output logic [3:0]            handle_o,
  output logic [stt_pkg::IntW-1:0] wait_ms_o,
  output logic                  last_o
);
  import stt_pkg::*;

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned DW = TimeW + IntW;

  typedef enum logic [2:0] {
    StIdle, StRead, StScan, StOut, StFlush
  } state_e;

  state_e state_q;
  logic [IntW-1:0] cap_q;
  logic [NUM_TIMERS-1:0] use_q, uns_q;
  logic [2:0] req_q;
  logic [3:0] slot_q;
  logic [IntW-1:0] first_q, second_q, best_q;
  logic [TimeW-1:0] now_q;
  logic [CW-1:0] idx_q;      // next slot to read
  logic [AW-1:0] cur_q;      // slot whose data is on rdata
  logic          due_any_q;
  result_t res_q;
  result_t out_q;
  logic    ovalid_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  stt_mem #(.Depth(NUM_TIMERS), .AddrW(AW), .DataW(DW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [TimeW-1:0] r_trig, delta;
  logic [IntW-1:0]  r_per;
  logic             r_live, r_due;
  assign r_trig = rdata[DW-1:IntW];
  assign r_per  = rdata[IntW-1:0];
  assign delta  = r_trig - now_q;
  assign r_due  = (delta == '0) || delta[TimeW-1];
  assign r_live = use_q[cur_q] && !uns_q[cur_q];

  // lowest free slot
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic slot_ok;
  assign slot_ok = ({28'd0, slot_q} < 32'(NUM_TIMERS)) && use_q[AW'(slot_q)];

  logic in_acc, out_free;
  assign out_free  = !ovalid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc    = in_valid_i && !in_stall_o;

  logic scan_fire;
  assign scan_fire = (state_q == StScan) && (req_q == ReqExec) && r_live && r_due;

  // output register load: a fired word during the walk, or the final word
  logic load_out;
  assign load_out = (scan_fire && out_free) || (state_q == StOut && out_free);

  result_t next_word;
  always_comb begin
    next_word = '{kind: KindFired, handle: 4'(cur_q), wait_ms: '0, last: 1'b0};
    if (state_q == StOut) next_word = res_q;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = {r_trig + {1'b0, r_per}, r_per};
    raddr = idx_q[AW-1:0];
    if (state_q == StIdle && in_acc) begin
      raddr = '0;
    end
    if (state_q == StRead) begin
      if (req_q == ReqAdd) begin
        we = free_any; waddr = free_idx;
        wdata = {now_q + {1'b0, first_q}, second_q};
      end else if (req_q == ReqResch) begin
        we = slot_ok; waddr = AW'(slot_q);
        wdata = {now_q + {1'b0, first_q}, second_q};
      end
    end
    if (scan_fire && out_free) we = 1'b1;
    // hold the read of the current slot while its fired word waits on a busy output
    if (state_q == StScan && scan_fire && !out_free) raddr = cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q <= CapReset;
      use_q <= '0;
      uns_q <= '0;
      ovalid_q <= 1'b0;
      out_q <= '0;
      idx_q <= '0;
      cur_q <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (load_out) begin
        ovalid_q <= 1'b1;
        out_q <= next_word;
      end else if (ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            req_q <= req_type_i; slot_q <= slot_i;
            first_q <= first_interval_i; second_q <= second_interval_i;
            now_q <= now_ms_i;
            best_q <= cap_q;
            due_any_q <= 1'b0;
            idx_q <= CW'(1);
            cur_q <= '0;
            if (req_type_i == ReqExec || req_type_i == ReqNext) state_q <= StScan;
            else if (req_type_i <= ReqRem) state_q <= StRead;
          end
        end
        StRead: begin
          res_q.wait_ms <= '0;
          res_q.last <= 1'b1;
          if (req_q == ReqAdd) begin
            res_q.kind <= free_any ? KindDone : KindFull;
            res_q.handle <= free_any ? 4'(free_idx) : '0;
            if (free_any) begin
              use_q[free_idx] <= 1'b1; uns_q[free_idx] <= 1'b0;
            end
          end else begin
            res_q.handle <= slot_q;
            res_q.kind <= slot_ok ? KindDone : KindNoSuch;
            if (slot_ok) begin
              case (req_q)
                ReqResch: uns_q[AW'(slot_q)] <= 1'b0;
                ReqUnsch: uns_q[AW'(slot_q)] <= 1'b1;
                default: begin
                  use_q[AW'(slot_q)] <= 1'b0; uns_q[AW'(slot_q)] <= 1'b0;
                end
              endcase
            end
          end
          state_q <= StOut;
        end
        StScan: begin
          if (!(scan_fire && !out_free)) begin
            if (scan_fire) begin
              if (r_per == '0) begin
                use_q[cur_q] <= 1'b0; uns_q[cur_q] <= 1'b0;
              end
            end
            if (req_q == ReqNext && r_live) begin
              if (r_due) due_any_q <= 1'b1;
              else if (delta < {1'b0, best_q}) best_q <= delta[IntW-1:0];
            end
            if (32'(cur_q) == NUM_TIMERS - 1) begin
              state_q <= StFlush;
            end else begin
              cur_q <= idx_q[AW-1:0];
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        StFlush: begin
          res_q.handle <= '0;
          res_q.last <= 1'b1;
          if (req_q == ReqExec) begin
            res_q.kind <= KindScan; res_q.wait_ms <= '0;
          end else begin
            res_q.kind <= KindWait;
            res_q.wait_ms <= due_any_q ? '0 : best_q;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      // StRead/StFlush write res_q while a fired word may still wait
    end
  end

  assign out_valid_o   = ovalid_q;
  assign result_kind_o = out_q.kind;
  assign handle_o      = out_q.handle;
  assign wait_ms_o     = out_q.wait_ms;
  assign last_o        = out_q.last;
endmodule
